FILE: sv/sphdp_pkg.sv
// Shared types and constants for the SPH density and pressure accumulator.
package sphdp_pkg;

    localparam int unsigned OFS_W   = 28;
    localparam int unsigned DSQ_W   = 57;
    localparam int unsigned RSQ_W   = 56;
    localparam int unsigned INV_W   = 24;
    localparam int unsigned SUM_W   = 23;
    localparam int unsigned K_W     = 16;
    localparam int unsigned Q_W     = 17;
    localparam int unsigned DIST_W  = 29;
    localparam int unsigned P_W     = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 56;

    localparam logic [SUM_W-1:0] SUM_MAX = 23'd4194304;
    localparam logic [Q_W-1:0]   ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_RSQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KNEAR = 3'd4;

    // Classified candidate handed from front to back.
    typedef struct packed {
        logic              accept;
        logic              last;
        logic [DSQ_W-1:0]  dsq;
    } t_cand;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_RATIO, ST_Q2, ST_Q3, ST_PRES, ST_PNEAR, ST_OUT
    } t_bstate;

endpackage

FILE: sv/sphdp_front.sv
// Front end: squares offsets, applies self, support and neighbour-limit checks.
module sphdp_front #(
    parameter int unsigned MAX_NEIGHBOURS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [sphdp_pkg::OFS_W-1:0] i_dx,
    input  logic signed [sphdp_pkg::OFS_W-1:0] i_dy,
    input  logic                              i_self,
    input  logic                              i_last,
    input  logic [sphdp_pkg::RSQ_W-1:0]       i_rsq,
    output logic                              o_valid,
    input  logic                              i_ready,
    output sphdp_pkg::t_cand                  o_cand
);
    localparam int unsigned CNT_W = $clog2(MAX_NEIGHBOURS + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [2*sphdp_pkg::OFS_W-1:0] w_sx, w_sy;
    logic [sphdp_pkg::DSQ_W-1:0] w_dsq;
    logic w_acc, w_fire;

    assign o_ready = !o_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_sx    = i_dx * i_dx;
    assign w_sy    = i_dy * i_dy;
    assign w_dsq   = {1'b0, w_sx} + {1'b0, w_sy};
    assign w_acc   = !i_self && (w_dsq < {1'b0, i_rsq})
                     && (r_cnt < CNT_W'(MAX_NEIGHBOURS));

    // Count accepted neighbours, clear at the end of a particle.
    always_comb begin
        n_cnt = r_cnt;
        if (w_fire) begin
            if (i_last) n_cnt = '0;
            else if (w_acc) n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (o_ready) o_valid <= i_valid;
        end
    end

    // Hold the classified candidate for the queue.
    always_ff @(posedge i_clk) begin
        if (w_fire) o_cand <= '{accept: w_acc, last: i_last, dsq: w_dsq};
    end
endmodule

FILE: sv/sphdp_fifo.sv
// Short queue between front and back ends.
module sphdp_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sphdp_pkg::t_cand i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output sphdp_pkg::t_cand o_data
);
    localparam int unsigned AW = $clog2(DEPTH);

    sphdp_pkg::t_cand r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic w_wr, w_rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: sv/sphdp_back.sv
// Back end: square root, weights, saturating sums and pressures.
module sphdp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  sphdp_pkg::t_cand                  i_cand,
    input  logic [sphdp_pkg::INV_W-1:0]       i_inv,
    input  logic [sphdp_pkg::SUM_W-1:0]       i_rest,
    input  logic [sphdp_pkg::K_W-1:0]         i_k,
    input  logic [sphdp_pkg::K_W-1:0]         i_knear,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_in_support,
    output logic [sphdp_pkg::Q_W-1:0]         o_q,
    output logic [sphdp_pkg::Q_W-1:0]         o_q2,
    output logic                              o_done,
    output logic [sphdp_pkg::SUM_W-1:0]       o_dens,
    output logic [sphdp_pkg::SUM_W-1:0]       o_ndens,
    output logic signed [sphdp_pkg::P_W-1:0]  o_pres,
    output logic signed [sphdp_pkg::P_W-1:0]  o_npres
);
    localparam int unsigned DW = sphdp_pkg::DSQ_W + 1;
    localparam int unsigned RW = sphdp_pkg::DIST_W;

    sphdp_pkg::t_bstate r_st, n_st;
    logic [DW-1:0] r_val;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [4:0]    r_it;
    logic          r_acc, r_last;
    logic [sphdp_pkg::Q_W-1:0] r_qv, r_q2v;
    logic [sphdp_pkg::SUM_W-1:0] r_far, r_near;
    logic [sphdp_pkg::SUM_W:0] w_farsum, w_nearsum;
    logic [sphdp_pkg::Q_W-1:0] w_q3;
    logic [RW+sphdp_pkg::INV_W-1:0] w_prod;
    logic [RW+sphdp_pkg::INV_W-17:0] w_ratio;
    logic [2*sphdp_pkg::Q_W-1:0] w_qq;
    logic [RW+1:0] w_trial;
    logic [RW+2:0] w_cur;
    logic signed [sphdp_pkg::SUM_W:0] w_d;
    logic signed [sphdp_pkg::SUM_W+sphdp_pkg::K_W+1:0] w_pm;
    logic signed [sphdp_pkg::SUM_W+sphdp_pkg::K_W-7:0] w_psh;
    logic signed [sphdp_pkg::P_W-1:0] w_psat;
    logic w_take;

    assign o_ready = (r_st == sphdp_pkg::ST_IDLE);
    assign w_take  = i_valid && o_ready;

    // One root bit per cycle: bring down two value bits, try {root, 01}.
    assign w_cur    = {r_rem, r_val[DW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_prod   = r_root * i_inv;
    assign w_ratio  = w_prod[RW+sphdp_pkg::INV_W-1:16];
    assign w_qq     = r_qv * (r_st == sphdp_pkg::ST_Q2 ? r_qv : r_q2v);
    assign w_q3     = w_qq[sphdp_pkg::Q_W+15:16];
    assign w_farsum  = {1'b0, r_far}
                       + {{(sphdp_pkg::SUM_W-sphdp_pkg::Q_W+1){1'b0}}, r_q2v};
    assign w_nearsum = {1'b0, r_near}
                       + {{(sphdp_pkg::SUM_W-sphdp_pkg::Q_W+1){1'b0}}, w_q3};

    // Pressure: multiply shared between far and near, floor shift by 8.
    always_comb begin
        if (r_st == sphdp_pkg::ST_PRES)
            w_d = $signed({1'b0, r_far}) - $signed({1'b0, i_rest});
        else
            w_d = $signed({1'b0, r_near});
        w_pm = w_d * $signed({2'b0, (r_st == sphdp_pkg::ST_PRES) ? i_k : i_knear});
        w_psh = w_pm[sphdp_pkg::SUM_W+sphdp_pkg::K_W+1:8];
        w_psat = w_psh[sphdp_pkg::P_W-1:0];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            sphdp_pkg::ST_IDLE:  if (w_take) n_st = i_cand.accept ? sphdp_pkg::ST_SQRT
                                     : (i_cand.last ? sphdp_pkg::ST_PRES : sphdp_pkg::ST_OUT);
            sphdp_pkg::ST_SQRT:  if (r_it == 5'd0) n_st = sphdp_pkg::ST_RATIO;
            sphdp_pkg::ST_RATIO: n_st = sphdp_pkg::ST_Q2;
            sphdp_pkg::ST_Q2:    n_st = sphdp_pkg::ST_Q3;
            sphdp_pkg::ST_Q3:    n_st = r_last ? sphdp_pkg::ST_PRES : sphdp_pkg::ST_OUT;
            sphdp_pkg::ST_PRES:  n_st = sphdp_pkg::ST_PNEAR;
            sphdp_pkg::ST_PNEAR: n_st = sphdp_pkg::ST_OUT;
            sphdp_pkg::ST_OUT:   if (i_ready) n_st = sphdp_pkg::ST_IDLE;
            default:             n_st = sphdp_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = (r_st == sphdp_pkg::ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= sphdp_pkg::ST_IDLE;
            r_far  <= '0;
            r_near <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == sphdp_pkg::ST_Q3) begin
                r_far  <= (w_farsum > {1'b0, sphdp_pkg::SUM_MAX}) ? sphdp_pkg::SUM_MAX
                          : w_farsum[sphdp_pkg::SUM_W-1:0];
                r_near <= (w_nearsum > {1'b0, sphdp_pkg::SUM_MAX}) ? sphdp_pkg::SUM_MAX
                          : w_nearsum[sphdp_pkg::SUM_W-1:0];
            end
            if (r_st == sphdp_pkg::ST_OUT && i_ready && r_last) begin
                r_far  <= '0;
                r_near <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            sphdp_pkg::ST_IDLE: if (w_take) begin
                r_val  <= {1'b0, i_cand.dsq};
                r_rem  <= '0;
                r_root <= '0;
                r_it   <= 5'd28;
                r_acc  <= i_cand.accept;
                r_last <= i_cand.last;
                r_qv   <= '0;
                r_q2v  <= '0;
            end
            sphdp_pkg::ST_SQRT: begin
                if (w_cur >= {1'b0, w_trial}) begin
                    r_rem  <= (RW+1)'(w_cur - {1'b0, w_trial});
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_cur[RW:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_val <= {r_val[DW-3:0], 2'b00};
                r_it  <= r_it - 1'b1;
            end
            sphdp_pkg::ST_RATIO: begin
                if (w_ratio >= (RW+sphdp_pkg::INV_W-16)'(sphdp_pkg::ONE_Q16))
                    r_qv <= '0;
                else
                    r_qv <= sphdp_pkg::ONE_Q16 - w_ratio[sphdp_pkg::Q_W-1:0];
            end
            sphdp_pkg::ST_Q2:    r_q2v <= w_qq[sphdp_pkg::Q_W+15:16];
            sphdp_pkg::ST_PRES:  o_pres <= ((w_psh > $signed(33'sd2147483647)) ? 32'sh7fffffff
                                 : (w_psh < -$signed(33'sd2147483648)) ? 32'sh80000000 : w_psat);
            sphdp_pkg::ST_PNEAR: o_npres <= (w_psh > $signed(33'sd2147483647)) ? 32'sh7fffffff
                                 : w_psat;
            default: ;
        endcase
    end

    assign o_in_support = r_acc;
    assign o_q     = r_qv;
    assign o_q2    = r_q2v;
    assign o_done  = r_last;
    assign o_dens  = r_last ? r_far : '0;
    assign o_ndens = r_last ? r_near : '0;
endmodule

FILE: sv/sph_density_pressure_accumulator.sv
// Top level of the SPH density and pressure accumulator.
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      offsets, is_self, last
//   m_axis    out  m_axis_tvalid/tready      weights, densities, pressures
//   cfg       in   i_cfg_valid/o_cfg_ready   register index and data
// The front end squares and classifies one candidate a cycle into a four-entry queue,
// while the queue has room. The back end takes one candidate at a time: bit-serial root,
// ratio, q2, q3 if accepted, then far and near pressure if last, then the output beat.
// A stalled m_axis holds the back end; the queue then fills and s_axis_tready drops.
// Reset is synchronous, active low, and clears sums, counts and queue.
module sph_density_pressure_accumulator #(
    parameter int unsigned MAX_NEIGHBOURS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // offset_x, offset_y
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,   // is_self
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // weight_q, weight_q_sq, density, near_density,
                                         // pressure, near_pressure, zero pad
    output logic         m_axis_tlast,   // done_res
    output logic         m_axis_tuser,   // in_support
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [55:0]  i_cfg_data
);
    logic [sphdp_pkg::RSQ_W-1:0] r_rsq;
    logic [sphdp_pkg::INV_W-1:0] r_inv;
    logic [sphdp_pkg::SUM_W-1:0] r_rest;
    logic [sphdp_pkg::K_W-1:0]   r_k, r_knear;
    logic f_valid, f_ready, q_valid, q_ready;
    sphdp_pkg::t_cand f_cand, q_cand;
    logic w_q_in, w_done;
    logic [sphdp_pkg::Q_W-1:0] w_q, w_q2;
    logic [sphdp_pkg::SUM_W-1:0] w_d, w_nd;
    logic signed [sphdp_pkg::P_W-1:0] w_p, w_np;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsq   <= 56'd4294967296;
            r_inv   <= 24'd65536;
            r_rest  <= '0;
            r_k     <= 16'd256;
            r_knear <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sphdp_pkg::REG_RSQ:   r_rsq   <= i_cfg_data;
                sphdp_pkg::REG_INV:   r_inv   <= i_cfg_data[sphdp_pkg::INV_W-1:0];
                sphdp_pkg::REG_REST:  r_rest  <= i_cfg_data[sphdp_pkg::SUM_W-1:0];
                sphdp_pkg::REG_K:     r_k     <= i_cfg_data[sphdp_pkg::K_W-1:0];
                sphdp_pkg::REG_KNEAR: r_knear <= i_cfg_data[sphdp_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    sphdp_front #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_dx(s_axis_tdata[27:0]), .i_dy(s_axis_tdata[55:28]),
        .i_self(s_axis_tuser), .i_last(s_axis_tlast), .i_rsq(r_rsq),
        .o_valid(f_valid), .i_ready(f_ready), .o_cand(f_cand)
    );

    sphdp_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cand),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cand)
    );

    sphdp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_cand(q_cand),
        .i_inv(r_inv), .i_rest(r_rest), .i_k(r_k), .i_knear(r_knear),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_in_support(w_q_in), .o_q(w_q), .o_q2(w_q2), .o_done(w_done),
        .o_dens(w_d), .o_ndens(w_nd), .o_pres(w_p), .o_npres(w_np)
    );

    assign m_axis_tuser = w_q_in;
    assign m_axis_tlast = w_done;
    assign m_axis_tdata = {8'd0, (w_done ? w_np : 32'sd0), (w_done ? w_p : 32'sd0),
                           w_nd, w_d, w_q2, w_q};

`ifndef NO_ASSERTIONS
    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:0] == 34'd0)
        else $error("weight without support");
    a_dens_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[79:34] == 46'd0)
        else $error("density outside done");
    a_dens_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[56:34] <= 23'd4194304)
        else $error("density over limit");
`endif
endmodule
